FILE: sv/wfg_pkg.sv
// ----------------------------------------------------------------------------
// wfg_pkg
// Shared types and constants for the wait-for graph deadlock detector.
// ----------------------------------------------------------------------------
package wfg_pkg;

    localparam int SLOTS_DEF     = 64;
    localparam int MAX_WAITS_DEF = 8;
    localparam int TXN_BITS_DEF  = 32;
    localparam int LOCK_BITS_DEF = 16;
    localparam logic [15:0] CEILING_RESET = 16'd1000;

    typedef enum logic [2:0] {
        FUNC_SET_OWNER = 3'd0,
        FUNC_ADD_DEP   = 3'd1,
        FUNC_REMOVE    = 3'd2,
        FUNC_CLEAR     = 3'd3,
        FUNC_DETECT    = 3'd4
    } func_t;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_MV,
        ST_ADD_WR,
        ST_RM_SLOT,
        ST_RM_RD,
        ST_RM_CHK,
        ST_RM_END,
        ST_DT_CLR,
        ST_DT_ENTER,
        ST_DT_ENTER2,
        ST_DT_LOOP,
        ST_DT_ERD,
        ST_DT_EVAL,
        ST_DT_NRD,
        ST_DT_NCHK,
        ST_DT_POP,
        ST_DT_POP2,
        ST_DONE
    } state_t;

endpackage

FILE: sv/wfg_mem.sv
// ----------------------------------------------------------------------------
// wfg_mem
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module wfg_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/wait_for_graph_deadlock_detector.sv
// Set owner and clear read the slot record and write it back; add dependency
// reads the record, shifts the list up one entry at a time and inserts at the head;
// remove walks the list of every slot in the whole table; detect scans list
// entries and enters slots below the start. One item is in work at a time; the
// walk over the entry memory sets the rate. After reset a pass loads the
// owner stamps, lock counts and list lengths before any item is taken.
// ----------------------------------------------------------------------------
// wait_for_graph_deadlock_detector
// Wait-for graph kept in RAMs, with a sequencer for edits and a depth-first
// cycle search that uses an explicit stack memory.
// ----------------------------------------------------------------------------
module wait_for_graph_deadlock_detector #(
    parameter int SLOTS     = wfg_pkg::SLOTS_DEF,
    parameter int MAX_WAITS = wfg_pkg::MAX_WAITS_DEF,
    parameter int TXN_BITS  = wfg_pkg::TXN_BITS_DEF,
    parameter int LOCK_BITS = wfg_pkg::LOCK_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_func,
    input  logic [5:0]           s_slot,
    input  logic [TXN_BITS-1:0]  s_txn_id,
    input  logic [LOCK_BITS-1:0] s_num_locks,
    input  logic [TXN_BITS-1:0]  s_dep_txn,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_status,
    output logic                 m_deadlock,
    output logic                 m_victim_found,
    output logic [TXN_BITS-1:0]  m_victim_txn
);

    localparam int SB = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WB = (MAX_WAITS > 1) ? $clog2(MAX_WAITS) : 1;
    localparam int LB = $clog2(MAX_WAITS + 1);
    localparam int EB = SB + WB;
    localparam int ED = SLOTS * MAX_WAITS;
    localparam int SW = SB + LB; // stack word: slot and next list index
    localparam int CB = 16;      // ceiling width
    localparam int BW = (LOCK_BITS > CB) ? LOCK_BITS : CB;

    // slot record: stamp, locks, length
    localparam int RW = TXN_BITS + LOCK_BITS + LB;

    // -------------------------------------------------------------------
    // registers
    // -------------------------------------------------------------------
    wfg_pkg::state_t state_reg, state_next;
    logic [CB-1:0]        ceil_reg;
    logic [2:0]           func_reg, func_next;
    logic [SB-1:0]        slot_reg, slot_next;
    logic [TXN_BITS-1:0]  txn_reg, txn_next;
    logic [LOCK_BITS-1:0] lk_reg, lk_next;
    logic [TXN_BITS-1:0]  dep_reg, dep_next;
    logic [SB:0]          cnt_reg, cnt_next;
    logic [LB-1:0]        k_reg, k_next;
    logic [LB-1:0]        w_reg, w_next;
    logic [LB-1:0]        len_reg, len_next;
    logic [TXN_BITS-1:0]  e_reg, e_next;
    logic [SB:0]          sp_reg, sp_next;
    logic [SLOTS-1:0]     vis_reg, vis_next;
    logic [SLOTS-1:0]     onp_reg, onp_next;
    logic                 seen_reg, seen_next;
    logic                 onl_reg, onl_next;
    logic                 lsv_reg, lsv_next;
    logic [SB-1:0]        ls_reg, ls_next;
    logic [BW-1:0]        best_reg, best_next;
    logic                 bv_reg, bv_next;
    logic [TXN_BITS-1:0]  bt_reg, bt_next;
    logic [RW-1:0]        cur_reg, cur_next; // record of the slot on top
    logic                 ov_reg, ov_next;
    logic                 o_st_reg, o_st_next;
    logic                 o_dl_reg, o_dl_next;
    logic                 o_vf_reg, o_vf_next;
    logic [TXN_BITS-1:0]  o_vt_reg, o_vt_next;

    // memory ports
    logic              r_we;
    logic [SB-1:0]     r_wa, r_ra;
    logic [RW-1:0]     r_wd, r_rd;
    logic              e_we;
    logic [EB-1:0]     e_wa, e_ra;
    logic [TXN_BITS-1:0] e_wd, e_rd;
    logic              k_we;
    logic [SB-1:0]     k_wa, k_ra;
    logic [SW-1:0]     k_wd, k_rd;

    wfg_mem #(.DEPTH(SLOTS), .WIDTH(RW)) u_rec (
        .aclk(aclk), .we(r_we), .waddr(r_wa), .wdata(r_wd), .raddr(r_ra), .rdata(r_rd)
    );
    wfg_mem #(.DEPTH(ED), .WIDTH(TXN_BITS)) u_ent (
        .aclk(aclk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd)
    );
    wfg_mem #(.DEPTH(SLOTS), .WIDTH(SW)) u_stk (
        .aclk(aclk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd)
    );

    // record fields
    function automatic logic [TXN_BITS-1:0] rstamp(input logic [RW-1:0] r);
        return r[RW-1 -: TXN_BITS];
    endfunction
    function automatic logic [LOCK_BITS-1:0] rlocks(input logic [RW-1:0] r);
        return r[LB +: LOCK_BITS];
    endfunction
    function automatic logic [LB-1:0] rlen(input logic [RW-1:0] r);
        return r[LB-1:0];
    endfunction
    function automatic logic [SB-1:0] slot_of(input logic [TXN_BITS-1:0] t);
        return SB'(t % SLOTS);
    endfunction
    function automatic logic [EB-1:0] eaddr(input logic [SB-1:0] s, input logic [LB-1:0] k);
        return EB'(s) * EB'(MAX_WAITS) + EB'(k);
    endfunction

    // top-of-stack slot and slot of the entry txn
    logic [SB-1:0] top_s;
    logic [SB-1:0] en_s;
    assign top_s = slot_of(rstamp(cur_reg));
    assign en_s  = slot_of(e_reg);

    assign s_ready = (state_reg == wfg_pkg::ST_IDLE) && !ov_reg;
    assign m_valid = ov_reg;
    assign m_status = o_st_reg;
    assign m_deadlock = o_dl_reg;
    assign m_victim_found = o_vf_reg;
    assign m_victim_txn = o_vt_reg;

    // -------------------------------------------------------------------
    // sequencer
    // -------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        func_next = func_reg; slot_next = slot_reg; txn_next = txn_reg;
        lk_next = lk_reg; dep_next = dep_reg; cnt_next = cnt_reg;
        k_next = k_reg; w_next = w_reg; len_next = len_reg; e_next = e_reg;
        sp_next = sp_reg; vis_next = vis_reg; onp_next = onp_reg;
        seen_next = seen_reg; onl_next = onl_reg; lsv_next = lsv_reg;
        ls_next = ls_reg; best_next = best_reg; bv_next = bv_reg; bt_next = bt_reg;
        cur_next = cur_reg; ov_next = ov_reg;
        o_st_next = o_st_reg; o_dl_next = o_dl_reg;
        o_vf_next = o_vf_reg; o_vt_next = o_vt_reg;
        r_we = 1'b0; r_wa = slot_reg; r_wd = cur_reg; r_ra = slot_reg;
        e_we = 1'b0; e_wa = '0; e_wd = dep_reg; e_ra = '0;
        k_we = 1'b0; k_wa = '0; k_wd = '0; k_ra = '0;

        if (ov_reg && m_ready) begin
            ov_next = 1'b0;
        end

        case (state_reg)
            // load reset records
            wfg_pkg::ST_INIT: begin
                r_we = 1'b1;
                r_wa = cnt_reg[SB-1:0];
                r_wd = {TXN_BITS'(cnt_reg[SB-1:0]), LOCK_BITS'(0), LB'(0)};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (SB+1)'(SLOTS - 1)) begin
                    state_next = wfg_pkg::ST_IDLE;
                end
            end
            wfg_pkg::ST_IDLE: begin
                if (s_valid && !ov_reg) begin
                    func_next = s_func;
                    slot_next = SB'(s_slot % SLOTS);
                    txn_next = s_txn_id; lk_next = s_num_locks; dep_next = s_dep_txn;
                    o_st_next = 1'b0; o_dl_next = 1'b0; o_vf_next = 1'b0; o_vt_next = '0;
                    cnt_next = '0;
                    case (s_func)
                        wfg_pkg::FUNC_SET_OWNER: state_next = wfg_pkg::ST_ADD_RD;
                        wfg_pkg::FUNC_ADD_DEP: state_next = wfg_pkg::ST_ADD_RD;
                        wfg_pkg::FUNC_CLEAR: begin
                            slot_next = slot_of(s_txn_id);
                            state_next = wfg_pkg::ST_ADD_RD;
                        end
                        wfg_pkg::FUNC_REMOVE: state_next = wfg_pkg::ST_RM_SLOT;
                        wfg_pkg::FUNC_DETECT: state_next = wfg_pkg::ST_DT_CLR;
                        default: state_next = wfg_pkg::ST_DONE;
                    endcase
                end
            end
            // read the slot record
            wfg_pkg::ST_ADD_RD: begin
                r_ra = slot_reg;
                state_next = wfg_pkg::ST_ADD_MV;
                k_next = '0;
            end
            // record arrives; apply set owner or clear, or check room for a new entry
            wfg_pkg::ST_ADD_MV: begin
                if (k_reg == '0) begin
                    cur_next = r_rd;
                end
                case (func_reg)
                    wfg_pkg::FUNC_SET_OWNER: begin
                        r_we = 1'b1;
                        r_wd = {txn_reg, lk_reg, rlen(r_rd)};
                        state_next = wfg_pkg::ST_DONE;
                    end
                    wfg_pkg::FUNC_CLEAR: begin
                        r_we = 1'b1;
                        r_wd = {rstamp(r_rd), LOCK_BITS'(0), LB'(0)};
                        state_next = wfg_pkg::ST_DONE;
                    end
                    default: begin
                        if (rlen(r_rd) >= LB'(MAX_WAITS)) begin
                            o_st_next = 1'b1;
                            state_next = wfg_pkg::ST_DONE;
                        end else begin
                            len_next = rlen(r_rd);
                            k_next = rlen(r_rd);
                            state_next = wfg_pkg::ST_ADD_WR;
                        end
                    end
                endcase
            end
            // shift entries up one, then insert at the head
            wfg_pkg::ST_ADD_WR: begin
                if (k_reg == '0) begin
                    e_we = 1'b1; e_wa = eaddr(slot_reg, '0); e_wd = dep_reg;
                    r_we = 1'b1;
                    r_wd = {rstamp(cur_reg), rlocks(cur_reg), len_reg + 1'b1};
                    state_next = wfg_pkg::ST_DONE;
                end else begin
                    e_ra = eaddr(slot_reg, k_reg - 1'b1);
                    state_next = wfg_pkg::ST_RM_END;
                    func_next = wfg_pkg::FUNC_ADD_DEP;
                end
            end
            // remove: read slot record
            wfg_pkg::ST_RM_SLOT: begin
                r_ra = cnt_reg[SB-1:0];
                slot_next = cnt_reg[SB-1:0];
                k_next = '0; w_next = '0;
                state_next = wfg_pkg::ST_RM_RD;
            end
            wfg_pkg::ST_RM_RD: begin
                if (k_reg == '0 && w_reg == '0) begin
                    cur_next = r_rd;
                end
                if (k_reg >= ((k_reg == '0 && w_reg == '0) ? rlen(r_rd) : rlen(cur_reg))) begin
                    r_we = 1'b1;
                    r_wd = {rstamp(cur_reg), rlocks(cur_reg), w_reg};
                    if (k_reg == '0 && w_reg == '0) begin
                        r_wd = {rstamp(r_rd), rlocks(r_rd), LB'(0)};
                    end
                    cnt_next = cnt_reg + 1'b1;
                    state_next = (cnt_reg == (SB+1)'(SLOTS - 1)) ? wfg_pkg::ST_DONE
                                                                 : wfg_pkg::ST_RM_SLOT;
                end else begin
                    e_ra = eaddr(slot_reg, k_reg);
                    state_next = wfg_pkg::ST_RM_CHK;
                end
            end
            wfg_pkg::ST_RM_CHK: begin
                if (e_rd != dep_reg) begin
                    e_we = 1'b1; e_wa = eaddr(slot_reg, w_reg); e_wd = e_rd;
                    w_next = w_reg + 1'b1;
                end
                k_next = k_reg + 1'b1;
                state_next = wfg_pkg::ST_RM_RD;
            end
            // add: entry k-1 read arrives, store at k
            wfg_pkg::ST_RM_END: begin
                e_we = 1'b1; e_wa = eaddr(slot_reg, k_reg); e_wd = e_rd;
                k_next = k_reg - 1'b1;
                state_next = wfg_pkg::ST_ADD_WR;
            end
            // detect: clear marks and search state
            wfg_pkg::ST_DT_CLR: begin
                vis_next = '0; onp_next = '0;
                seen_next = 1'b0; onl_next = 1'b0; lsv_next = 1'b0; ls_next = '0;
                best_next = BW'(ceil_reg); bv_next = 1'b0; bt_next = '0;
                sp_next = '0;
                e_next = txn_reg;
                state_next = wfg_pkg::ST_DT_ENTER;
            end
            // enter a node whose txn is e_reg
            wfg_pkg::ST_DT_ENTER: begin
                r_ra = en_s;
                state_next = wfg_pkg::ST_DT_ENTER2;
            end
            wfg_pkg::ST_DT_ENTER2: begin
                vis_next[en_s] = 1'b1;
                if (rstamp(r_rd) != e_reg) begin
                    // only the stale start can reach here
                    state_next = wfg_pkg::ST_DT_POP2;
                end else begin
                    onp_next[en_s] = 1'b1;
                    cur_next = r_rd;
                    k_next = '0;
                    k_we = 1'b1; k_wa = sp_reg[SB-1:0]; k_wd = {en_s, LB'(0)};
                    sp_next = sp_reg + 1'b1;
                    state_next = wfg_pkg::ST_DT_LOOP;
                end
            end
            // next list entry of top node
            wfg_pkg::ST_DT_LOOP: begin
                if (k_reg >= rlen(cur_reg) || k_reg >= LB'(MAX_WAITS)) begin
                    state_next = wfg_pkg::ST_DT_POP;
                end else begin
                    e_ra = eaddr(top_s, k_reg);
                    state_next = wfg_pkg::ST_DT_ERD;
                end
            end
            wfg_pkg::ST_DT_ERD: begin
                e_next = e_rd;
                r_ra = slot_of(e_rd);
                state_next = wfg_pkg::ST_DT_EVAL;
            end
            wfg_pkg::ST_DT_EVAL: begin
                if (onp_reg[en_s] && e_reg == rstamp(r_rd)) begin
                    seen_next = 1'b1; onl_next = 1'b1;
                    ls_next = en_s; lsv_next = 1'b1;
                    state_next = wfg_pkg::ST_DT_POP;
                end else if (!vis_reg[en_s] && rstamp(r_rd) == e_reg) begin
                    // descend: save return index
                    k_we = 1'b1; k_wa = SB'(sp_reg - 1'b1);
                    k_wd = {top_s, LB'(k_reg + 1'b1)};
                    vis_next[en_s] = 1'b1; onp_next[en_s] = 1'b1;
                    cur_next = r_rd;
                    k_next = '0;
                    k_we = 1'b1;
                    state_next = wfg_pkg::ST_DT_NRD;
                end else begin
                    k_next = k_reg + 1'b1;
                    state_next = wfg_pkg::ST_DT_LOOP;
                end
            end
            // push the child
            wfg_pkg::ST_DT_NRD: begin
                k_we = 1'b1; k_wa = sp_reg[SB-1:0]; k_wd = {en_s, LB'(0)};
                sp_next = sp_reg + 1'b1;
                state_next = wfg_pkg::ST_DT_LOOP;
            end
            // finish the top node
            wfg_pkg::ST_DT_POP: begin
                onp_next[top_s] = 1'b0;
                if (seen_reg && onl_reg && BW'(rlocks(cur_reg)) < best_reg) begin
                    best_next = BW'(rlocks(cur_reg));
                    bt_next = rstamp(cur_reg);
                    bv_next = 1'b1;
                end
                if (lsv_reg && top_s == ls_reg) begin
                    onl_next = 1'b0;
                end
                sp_next = sp_reg - 1'b1;
                if (sp_reg == (SB+1)'(1)) begin
                    state_next = wfg_pkg::ST_DT_POP2;
                end else begin
                    k_ra = SB'(sp_reg - 2'd2);
                    state_next = wfg_pkg::ST_DT_NCHK;
                end
            end
            // parent frame arrives
            wfg_pkg::ST_DT_NCHK: begin
                if (cnt_reg[0] == 1'b0) begin
                    r_ra = k_rd[SW-1 -: SB];
                    k_next = k_rd[LB-1:0];
                    cnt_next = (SB+1)'(1);
                end else begin
                    cur_next = r_rd;
                    cnt_next = '0;
                    // child returned a loop: parent stops its scan
                    state_next = seen_reg ? wfg_pkg::ST_DT_POP : wfg_pkg::ST_DT_LOOP;
                end
            end
            wfg_pkg::ST_DT_POP2: begin
                o_dl_next = seen_reg;
                o_vf_next = seen_reg && bv_reg;
                o_vt_next = (seen_reg && bv_reg) ? bt_reg : '0;
                state_next = wfg_pkg::ST_DONE;
            end
            // present result
            wfg_pkg::ST_DONE: begin
                if (!ov_reg) begin
                    ov_next = 1'b1;
                    state_next = wfg_pkg::ST_IDLE;
                end
            end
            default: state_next = wfg_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wfg_pkg::ST_INIT;
            cnt_reg <= '0;
            ov_reg <= 1'b0;
            ceil_reg <= wfg_pkg::CEILING_RESET;
            sp_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            ov_reg <= ov_next;
            sp_reg <= sp_next;
            if (cfg_we) begin
                ceil_reg <= cfg_wdata;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        func_reg <= func_next; slot_reg <= slot_next; txn_reg <= txn_next;
        lk_reg <= lk_next; dep_reg <= dep_next; k_reg <= k_next; w_reg <= w_next;
        len_reg <= len_next; e_reg <= e_next; vis_reg <= vis_next; onp_reg <= onp_next;
        seen_reg <= seen_next; onl_reg <= onl_next; lsv_reg <= lsv_next;
        ls_reg <= ls_next; best_reg <= best_next; bv_reg <= bv_next; bt_reg <= bt_next;
        cur_reg <= cur_next; o_st_reg <= o_st_next; o_dl_reg <= o_dl_next;
        o_vf_reg <= o_vf_next; o_vt_reg <= o_vt_next;
    end

endmodule

FILE: sv/wfg_checker.sv
// ----------------------------------------------------------------------------
// wfg_checker
// Port-level checks for the deadlock detector, bound to the top level.
// ----------------------------------------------------------------------------
module wfg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_status,
    input logic        m_deadlock,
    input logic        m_victim_found,
    input logic [31:0] m_victim_txn
);

    // a victim only comes with a deadlock
    a_victim: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_victim_found |-> m_deadlock)
        else $error("victim without deadlock");

    // status and deadlock never together
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_status && m_deadlock))
        else $error("status and deadlock both set");

    // no input taken while a result waits
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while result pending");

    // result valid and victim txn hold until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_victim_txn))
        else $error("result dropped");

endmodule

bind wait_for_graph_deadlock_detector wfg_checker u_wfg_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_deadlock(m_deadlock), .m_victim_found(m_victim_found),
    .m_victim_txn(m_victim_txn)
);
